// ----- sv/arbh_pkg.sv -----
// Package for the AES round block hash: types, lane keys, S-box and round function.
// Depends on nothing; every module of the block imports it.
package arbh_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned NumWords = 8;
  localparam int unsigned NumLanes = 4;
  localparam int unsigned CntW    = 7;
  localparam logic [6:0]  BlockBytes = 7'd64;
  localparam logic [7:0]  LetterBase = 8'h41;
  localparam logic [3:0]  NibbleMask = 4'hF;
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = 2;

  localparam logic [63:0] LANE_KEYS [NumWords] = '{
    64'h343B2F2F2063686F, 64'h73656E2062792061,
    64'h2066616972206469, 64'h636520726F6C6C2E,
    64'h0A2F2F2067756172, 64'h616E746565642074,
    64'h6F2062652072616E, 64'h646F6D2E0BAD1DEA
  };

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // One classified block as it travels from the front end to the back end.
  typedef struct packed {
    logic [NumWords-1:0][WordW-1:0] data;
    logic                           active;
    logic                           last;
  } blk_req_t;

  typedef logic [127:0] lane_t;

  function automatic logic [7:0] gf_double(input logic [7:0] x);
    gf_double = {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
  endfunction

  // One AES encryption round; byte i of the state is lane bits 8i+7:8i.
  function automatic lane_t enc_round(input lane_t st, input lane_t key);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    lane_t      res;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r + 4*c] = SBOX[st[8*(r + 4*((c + r) % 4)) +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      res[8*(4*c)   +: 8] = a0 ^ al ^ gf_double(a0 ^ a1);
      res[8*(4*c+1) +: 8] = a1 ^ al ^ gf_double(a1 ^ a2);
      res[8*(4*c+2) +: 8] = a2 ^ al ^ gf_double(a2 ^ a3);
      res[8*(4*c+3) +: 8] = a3 ^ al ^ gf_double(a3 ^ a0);
    end
    enc_round = res ^ key;
  endfunction

endpackage

// ----- sv/arbh_front.sv -----
// Front end of the AES round block hash: accepts blocks, masks invalid bytes.
// Depends on arbh_pkg.
module arbh_front
  import arbh_pkg::*;
(
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [NumWords-1:0][WordW-1:0] words,
  input  logic [CntW-1:0]                valid_bytes,
  input  logic                           last_block,
  output logic                           q_push,
  input  logic                           q_full,
  output blk_req_t                       q_req
);

  logic [CntW-1:0] n_sat;

  // Counts above a full block saturate to the whole block.
  assign n_sat = (valid_bytes > BlockBytes) ? BlockBytes : valid_bytes;

  // Zero every byte at or beyond the valid count.
  always_comb begin
    for (int b = 0; b < 64; b++) begin
      q_req.data[b/8][8*(b%8) +: 8] =
        (CntW'(b) < n_sat) ? words[b/8][8*(b%8) +: 8] : 8'h00;
    end
    q_req.active = (n_sat != '0);
    q_req.last   = last_block;
  end

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;

endmodule

// ----- sv/arbh_queue.sv -----
// Short request queue between the front and back ends of the block hash.
// Depends on arbh_pkg.
module arbh_queue
  import arbh_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  blk_req_t push_req,
  output logic     full,
  input  logic     pop,
  output blk_req_t head_req,
  output logic     empty
);

  blk_req_t         mem_r [QDepth];
  logic [QPtrW-1:0] wp_r, rp_r;
  logic [QPtrW:0]   cnt_r;

  assign full     = (cnt_r == (QPtrW+1)'(QDepth));
  assign empty    = (cnt_r == '0);
  assign head_req = mem_r[rp_r];

  // Storage entries.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wp_r] <= push_req;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) wp_r <= wp_r + 1'b1;
      if (pop && !empty) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QPtrW+1)'(push && !full) - (QPtrW+1)'(pop && !empty);
    end
  end

endmodule

// ----- sv/arbh_back.sv -----
// Back end of the block hash: two pipelined AES rounds, accumulate, digest.
// Depends on arbh_pkg.
module arbh_back
  import arbh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  blk_req_t             q_head,
  output logic                 q_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [WordW-1:0]     out_digest_sum,
  output logic [WordW-1:0]     out_letters_low,
  output logic [WordW-1:0]     out_letters_high
);

  // Stages in order: first round; second round; accumulate and snapshot;
  // eight-word sum into the result register.
  lane_t [NumLanes-1:0] r1_r, r2_r;
  logic s1_v_r, s1_a_r, s1_l_r, s2_v_r, s2_a_r, s2_l_r;
  logic [NumWords-1:0][WordW-1:0] acc_r, snap_r;
  logic s4_v_r;
  logic [WordW-1:0] res_sum_r;
  logic res_v_r;
  logic s4_go, flow;
  logic [WordW-1:0] pair_sum [4];
  logic [WordW-1:0] quad_sum [2];
  logic [WordW-1:0] sum;
  logic [NumWords-1:0][WordW-1:0] acc_upd;

  // The result register can load unless a finished digest is stuck there.
  assign s4_go     = !(res_v_r && !out_pop);
  // The round pipeline moves unless a held digest blocks the digest stage.
  assign flow      = s4_go || (!(s2_v_r && s2_l_r) && !s4_v_r);
  assign q_pop     = !q_empty && flow;
  assign out_empty = !res_v_r;

  // Accumulator update and a balanced eight-word add.
  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      acc_upd[2*l]   = acc_r[2*l]   ^ (s2_a_r ? r2_r[l][63:0]   : '0);
      acc_upd[2*l+1] = acc_r[2*l+1] ^ (s2_a_r ? r2_r[l][127:64] : '0);
    end
    for (int p = 0; p < 4; p++) pair_sum[p] = snap_r[2*p] + snap_r[2*p+1];
    quad_sum[0] = pair_sum[0] + pair_sum[1];
    quad_sum[1] = pair_sum[2] + pair_sum[3];
    sum = quad_sum[0] + quad_sum[1];
  end

  // AES round stages.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int l = 0; l < NumLanes; l++) begin
        r1_r[l] <= enc_round({q_head.data[2*l+1], q_head.data[2*l]},
                             {LANE_KEYS[2*l+1], LANE_KEYS[2*l]});
      end
      s1_a_r <= q_head.active;
      s1_l_r <= q_head.last;
    end
    if (flow) begin
      for (int l = 0; l < NumLanes; l++) begin
        r2_r[l] <= enc_round(r1_r[l], {LANE_KEYS[2*l+1], LANE_KEYS[2*l]});
      end
      s2_a_r <= s1_a_r;
      s2_l_r <= s1_l_r;
    end
    if (flow && s2_v_r && s2_l_r) snap_r <= acc_upd;
    if (s4_go && s4_v_r) res_sum_r <= sum;
  end

  // Control and accumulator.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      res_v_r <= 1'b0;
      acc_r   <= '0;
    end else begin
      if (flow) begin
        s1_v_r <= q_pop;
        s2_v_r <= s1_v_r;
        if (s2_v_r) acc_r <= s2_l_r ? '0 : acc_upd;
      end
      if (s4_go) begin
        res_v_r <= s4_v_r;
        s4_v_r  <= flow && s2_v_r && s2_l_r;
      end else if (flow && s2_v_r && s2_l_r) begin
        s4_v_r <= 1'b1;
      end else if (out_pop && res_v_r) begin
        res_v_r <= 1'b0;
      end
    end
  end

  assign out_digest_sum = res_sum_r;
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      out_letters_low[8*k +: 8]  = LetterBase + {4'h0, res_sum_r[4*k +: 4] & NibbleMask};
      out_letters_high[8*k +: 8] = LetterBase + {4'h0, res_sum_r[4*(k+8) +: 4] & NibbleMask};
    end
  end

endmodule

// ----- sv/aes_round_block_hash.sv -----
// Top level of the AES round block hash: front end, request queue, back end.
// Depends on arbh_pkg, arbh_front, arbh_queue and arbh_back.
//
//   channel   handshake         payload
//   in_       in_push/in_full   in_data_word_0..7, in_valid_bytes, in_last_block
//   out_      out_pop/out_empty out_digest_sum, out_letters_low, out_letters_high
//
// One block enters per cycle while the queue is not full. A digest forms after its last
// block is accepted, in these steps: first AES round, second AES round with accumulate,
// snapshot, eight-word add into the result register.
// Reset clears the accumulator and all control; no clearing pass is needed.
// A held digest stalls the rounds once the snapshot stage is full or a last
// block reaches the accumulator; the four-entry queue absorbs input meanwhile.
module aes_round_block_hash
  import arbh_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic [63:0]      in_data_word_0,
  input  logic [63:0]      in_data_word_1,
  input  logic [63:0]      in_data_word_2,
  input  logic [63:0]      in_data_word_3,
  input  logic [63:0]      in_data_word_4,
  input  logic [63:0]      in_data_word_5,
  input  logic [63:0]      in_data_word_6,
  input  logic [63:0]      in_data_word_7,
  input  logic [6:0]       in_valid_bytes,
  input  logic             in_last_block,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [63:0]      out_digest_sum,
  output logic [63:0]      out_letters_low,
  output logic [63:0]      out_letters_high
);

  logic [NumWords-1:0][WordW-1:0] words;
  blk_req_t f_req, q_head;
  logic f_push, q_full, q_pop, q_empty;

  assign words = {in_data_word_7, in_data_word_6, in_data_word_5, in_data_word_4,
                  in_data_word_3, in_data_word_2, in_data_word_1, in_data_word_0};

  arbh_front u_front (
    .in_push, .in_full, .words,
    .valid_bytes(in_valid_bytes), .last_block(in_last_block),
    .q_push(f_push), .q_full, .q_req(f_req)
  );

  arbh_queue u_queue (
    .clk, .rst_n, .push(f_push), .push_req(f_req), .full(q_full),
    .pop(q_pop), .head_req(q_head), .empty(q_empty)
  );

  arbh_back u_back (
    .clk, .rst_n, .q_empty, .q_head, .q_pop, .out_empty, .out_pop,
    .out_digest_sum, .out_letters_low, .out_letters_high
  );

`ifndef SYNTHESIS
  // A held digest must not change while the consumer stalls.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> $stable(out_digest_sum)) else $error("digest moved");
  // The queue never reports full and empty together.
  a_q: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty)) else $error("queue state");
  // The first low letter has a high nibble of 4 or 5, the range that holds A to P.
  a_let: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_letters_low[7:4] == 4'h4 || out_letters_low[7:4] == 4'h5))
    else $error("letter range");
`endif

endmodule

// ----- tb/aes_round_block_hash_tb.sv -----
// Testbench for the AES round block hash: directed table, then random messages.
// Depends on arbh_pkg (sizes) and the aes_round_block_hash top level.
module aes_round_block_hash_tb;
  import arbh_pkg::*;

  typedef struct {
    logic [63:0] words [8];
    logic [6:0]  count;
    logic        last;
  } block_t;

  typedef struct {
    logic [63:0] sum;
    logic [63:0] lo;
    logic [63:0] hi;
  } digest_t;

  // Directed row: a block plus an optional typed-in expected digest.
  typedef struct {
    block_t      blk;
    logic        has_known;
    logic [63:0] known_sum;
  } row_t;

  localparam logic [63:0] ALL_A = 64'h4141414141414141;
  localparam logic [63:0] ALL_P = 64'h5050505050505050;
  localparam int unsigned NUM_RANDOM = 1750;
  localparam longint unsigned CYCLE_LIMIT = 200000;

  logic clk;
  logic rst_n;
  logic in_push;
  logic in_full;
  logic [63:0] in_w [8];
  logic [6:0] in_valid_bytes;
  logic in_last_block;
  logic out_empty;
  logic out_pop;
  logic [63:0] out_digest_sum;
  logic [63:0] out_letters_low;
  logic [63:0] out_letters_high;

  logic [63:0] hash_acc [8];
  digest_t digest_queue [$];
  int errors;
  int blocks_sent;
  int digests_seen;
  longint unsigned cycles;
  logic [7:0] sbox_tb [256];

  aes_round_block_hash uut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_data_word_0(in_w[0]), .in_data_word_1(in_w[1]),
    .in_data_word_2(in_w[2]), .in_data_word_3(in_w[3]),
    .in_data_word_4(in_w[4]), .in_data_word_5(in_w[5]),
    .in_data_word_6(in_w[6]), .in_data_word_7(in_w[7]),
    .in_valid_bytes(in_valid_bytes), .in_last_block(in_last_block),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_digest_sum(out_digest_sum), .out_letters_low(out_letters_low),
    .out_letters_high(out_letters_high)
  );

  // Clock with a period of 20.
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d digests outstanding", $time, digest_queue.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
  endfunction

  // Two AES rounds on one lane; byte i of the state sits in bits 8i+7:8i.
  function automatic logic [127:0] two_rounds(input logic [127:0] st_in,
                                              input logic [127:0] key);
    logic [127:0] st;
    logic [127:0] mixed;
    logic [7:0] sb [16];
    logic [7:0] a0, a1, a2, a3, tot;
    st = st_in;
    for (int rnd = 0; rnd < 2; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          sb[r + 4*c] = sbox_tb[st[8*(r + 4*((c + r) % 4)) +: 8]];
      for (int c = 0; c < 4; c++) begin
        a0 = sb[4*c]; a1 = sb[4*c+1]; a2 = sb[4*c+2]; a3 = sb[4*c+3];
        tot = a0 ^ a1 ^ a2 ^ a3;
        mixed[8*(4*c) +: 8]   = a0 ^ tot ^ xtime(a0 ^ a1);
        mixed[8*(4*c+1) +: 8] = a1 ^ tot ^ xtime(a1 ^ a2);
        mixed[8*(4*c+2) +: 8] = a2 ^ tot ^ xtime(a2 ^ a3);
        mixed[8*(4*c+3) +: 8] = a3 ^ tot ^ xtime(a3 ^ a0);
      end
      st = mixed ^ key;
    end
    two_rounds = st;
  endfunction

  function automatic digest_t letters_of(input logic [63:0] sum);
    digest_t d;
    d.sum = sum;
    for (int k = 0; k < 8; k++) begin
      d.lo[8*k +: 8] = LetterBase + 8'(sum[4*k +: 4]);
      d.hi[8*k +: 8] = LetterBase + 8'(sum[4*(k+8) +: 4]);
    end
    letters_of = d;
  endfunction

  // Fold one accepted block into the accumulator; queue a digest on the last one.
  task automatic absorb_block(input block_t b);
    int n;
    logic [63:0] masked [8];
    logic [127:0] res;
    logic [63:0] total;
    n = (b.count > BlockBytes) ? 64 : int'(b.count);
    if (n > 0) begin
      for (int w = 0; w < 8; w++) begin
        masked[w] = b.words[w];
        for (int by = 0; by < 8; by++)
          if (8*w + by >= n) masked[w][8*by +: 8] = 8'h00;
      end
      for (int ln = 0; ln < 4; ln++) begin
        res = two_rounds({masked[2*ln+1], masked[2*ln]},
                         {LANE_KEYS[2*ln+1], LANE_KEYS[2*ln]});
        hash_acc[2*ln] ^= res[63:0];
        hash_acc[2*ln+1] ^= res[127:64];
      end
    end
    if (b.last) begin
      total = '0;
      for (int w = 0; w < 8; w++) total += hash_acc[w];
      digest_queue.push_back(letters_of(total));
      for (int w = 0; w < 8; w++) hash_acc[w] = '0;
    end
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) gap_len = 0;
    else if (p < 93) gap_len = $urandom_range(1, 3);
    else gap_len = $urandom_range(8, 30);
  endfunction

  // Present one request and hold it until the block takes it.
  task automatic send_block(input block_t b);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_push <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_push <= 1'b1;
    for (int w = 0; w < 8; w++) in_w[w] <= b.words[w];
    in_valid_bytes <= b.count;
    in_last_block <= b.last;
    @(posedge clk);
    while (in_full) @(posedge clk);
    absorb_block(b);
    blocks_sent++;
  endtask

  function automatic block_t rand_block(input logic last);
    block_t b;
    int p;
    for (int w = 0; w < 8; w++) b.words[w] = {$urandom(), $urandom()};
    p = $urandom_range(0, 99);
    if (p < 55) b.count = 7'd64;
    else if (p < 90) b.count = 7'($urandom_range(1, 63));
    else if (p < 95) b.count = 7'd0;
    else b.count = 7'($urandom_range(65, 127));
    b.last = last;
    rand_block = b;
  endfunction

  // Result side: random pop stalls, compare each accepted digest.
  initial begin
    digest_t exp_d;
    int g;
    out_pop = 1'b0;
    @(posedge rst_n);
    forever begin
      g = gap_len();
      if (g > 0) begin
        out_pop <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
      digests_seen++;
      if (digest_queue.size() == 0) begin
        $display("%0t unexpected digest: expected none, actual %h", $time, out_digest_sum);
        errors++;
      end else begin
        exp_d = digest_queue.pop_front();
        if (out_digest_sum !== exp_d.sum) begin
          $display("%0t digest_sum: expected %h actual %h", $time, exp_d.sum, out_digest_sum);
          errors++;
        end
        if (out_letters_low !== exp_d.lo) begin
          $display("%0t letters_low: expected %h actual %h", $time, exp_d.lo, out_letters_low);
          errors++;
        end
        if (out_letters_high !== exp_d.hi) begin
          $display("%0t letters_high: expected %h actual %h", $time, exp_d.hi,
                   out_letters_high);
          errors++;
        end
      end
    end
  end

  // Stimulus: reset, directed table, then random messages.
  initial begin
    row_t rows [$];
    row_t rw;
    block_t b;
    int msg_len;
    logic [63:0] bit_pat;
    logic drained;
    sbox_tb = SBOX;
    errors = 0;
    blocks_sent = 0;
    digests_seen = 0;
    cycles = 0;
    drained = 1'b0;
    for (int w = 0; w < 8; w++) hash_acc[w] = '0;
    rst_n = 1'b0;
    in_push = 1'b0;
    for (int w = 0; w < 8; w++) in_w[w] = '0;
    in_valid_bytes = '0;
    in_last_block = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Build the table: empty message, zero count, extremes, saturation, partials.
    rw.has_known = 1'b1; rw.known_sum = '0;
    for (int w = 0; w < 8; w++) rw.blk.words[w] = '1;
    rw.blk.count = 7'd0; rw.blk.last = 1'b1; rows.push_back(rw);
    rw.blk.count = 7'd0; rw.blk.last = 1'b0; rw.has_known = 1'b0; rows.push_back(rw);
    rw.blk.count = 7'd0; rw.blk.last = 1'b1; rw.has_known = 1'b1; rows.push_back(rw);
    rw.has_known = 1'b0;
    for (int i = 0; i < 8; i++) begin
      bit_pat = (i % 2 == 0) ? 64'h0 : 64'hFFFF_FFFF_FFFF_FFFF;
      for (int w = 0; w < 8; w++) rw.blk.words[w] = (i >= 4) ? ~bit_pat : bit_pat;
      case (i)
        0: rw.blk.count = 7'd64;
        1: rw.blk.count = 7'd64;
        2: rw.blk.count = 7'd127;
        3: rw.blk.count = 7'd65;
        4: rw.blk.count = 7'd1;
        5: rw.blk.count = 7'd63;
        6: rw.blk.count = 7'd8;
        default: rw.blk.count = 7'd33;
      endcase
      rw.blk.last = 1'b1;
      rows.push_back(rw);
    end
    // A multi-block message with a partial tail.
    for (int i = 0; i < 4; i++) begin
      for (int w = 0; w < 8; w++) rw.blk.words[w] = {$urandom(), $urandom()};
      rw.blk.count = (i == 3) ? 7'd17 : 7'd64;
      rw.blk.last = (i == 3);
      rows.push_back(rw);
    end

    foreach (rows[i]) begin
      send_block(rows[i].blk);
      // Known values: nothing accumulated gives a zero sum and all 'A'.
      if (rows[i].has_known) begin
        if (digest_queue[$].sum !== rows[i].known_sum || digest_queue[$].lo !== ALL_A ||
            digest_queue[$].hi !== ALL_A) begin
          $display("%0t predictor: expected %h actual %h", $time, rows[i].known_sum,
                   digest_queue[$].sum);
          errors++;
        end
      end
    end
    // Sanity of the letter encoding at the top of the sum range.
    if (letters_of('1).lo !== ALL_P || letters_of('1).hi !== ALL_P) begin
      $display("%0t letters: expected %h actual %h", $time, ALL_P, letters_of('1).lo);
      errors++;
    end

    // Random messages: mostly one to four blocks of random count, ending in one last block.
    while (blocks_sent < NUM_RANDOM + rows.size()) begin
      msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 14) : $urandom_range(1, 4);
      for (int i = 0; i < msg_len; i++) begin
        b = rand_block(i == msg_len - 1);
        send_block(b);
      end
      // Hold off once until everything has drained.
      if (blocks_sent > 900 && !drained) begin
        drained = 1'b1;
        in_push <= 1'b0;
        @(posedge clk);
        while (digest_queue.size() != 0) @(posedge clk);
      end
    end
    // Close any open message so nothing is left in the accumulator.
    b = rand_block(1'b1);
    send_block(b);
    in_push <= 1'b0;

    while (digest_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d blocks and checked %0d digests, covering empty, partial,",
             blocks_sent, digests_seen);
    $display("saturated and multi-block messages under random stalls.");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
